// File: rtl/core/ptw_pkg.sv
`timescale 1ns / 1ps
// ptw_pkg: shared types, codes and constants of the page table walker.
// No dependencies; imported by every module of the walker.
package ptw_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [31:0] PDPT_ROOT_MASK  = 32'hFFFF_FFE0;
   localparam logic [31:0] DIR_ROOT_MASK   = 32'hFFFF_F000;

   // One classified item in the queue between front and back.
   // Start: payload = {root_base, virt_addr}. Data: payload = read_data.
   typedef struct packed {
      logic        is_start;
      logic [63:0] payload;
   } qent_type;

endpackage

// File: rtl/core/ptw_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the page table walker: request, response, csr write.
// No dependencies.
interface ptw_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] root_base;
   logic [31:0] virt_addr;
   logic [63:0] read_data;
   modport source (output valid, cmd, root_base, virt_addr, read_data, input ready);
   modport sink   (input valid, cmd, root_base, virt_addr, read_data, output ready);
endinterface

interface ptw_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [31:0] read_addr;
   logic        read_wide;
   logic [31:0] phys_addr;
   logic        fault;
   modport source (output valid, result_kind, read_addr, read_wide, phys_addr, fault,
                   input ready);
   modport sink   (input valid, result_kind, read_addr, read_wide, phys_addr, fault,
                   output ready);
endinterface

interface ptw_csr_if;
   logic valid;
   logic ready;
   logic pae_mode;
   modport source (output valid, pae_mode, input ready);
   modport sink   (input valid, pae_mode, output ready);
endinterface

// File: rtl/core/x86_page_table_walker.sv
`timescale 1ns / 1ps
// x86_page_table_walker: top level; front queue plus walk engine.
// Depends on ptw_pkg, ptw_if, ptw_front, ptw_back.
//
//   channel | dir | transfer carries
//   --------+-----+-----------------------------------------------------
//   req     | in  | cmd, root_base, virt_addr, read_data
//   rsp     | out | result_kind, read_addr, read_wide, phys_addr, fault
//   csr     | in  | pae_mode
//
// One item per cycle sustained while rsp is ready; a result reaches rsp through the
// queue slot, then the output register in the walk engine.
// Synchronous reset clears mode to classic, the walk to idle and empties the queue.
// A stalled rsp holds the output register; items keep entering until the
// QUEUE_DEPTH-entry queue is full. csr is always ready.
module x86_page_table_walker
   import ptw_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req,
   ptw_rsp_if.source rsp,
   ptw_csr_if.sink   csr
);

   logic     head_valid;
   qent_type head;
   logic     head_pop;

   ptw_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   ptw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .rsp        (rsp),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

endmodule

// File: rtl/core/ptw_front.sv
`timescale 1ns / 1ps
// ptw_front: accepts request items, classifies start vs. returning data,
// and queues them for the walk engine. Depends on ptw_pkg, ptw_if.
module ptw_front
   import ptw_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   ptw_req_if.sink   req,
   output logic      head_valid,
   output qent_type  head,
   input  logic      head_pop
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   qent_type          mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push;
   qent_type          entry;

   assign req.ready  = (count_ff != CW'(DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      entry.is_start = (req.cmd == CMD_START);
      if (req.cmd == CMD_START) begin
         entry.payload = {req.root_base, req.virt_addr};
      end else begin
         entry.payload = req.read_data;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: rtl/core/ptw_back.sv
`timescale 1ns / 1ps
// ptw_back: walk engine. Holds mode, phase and address under translation,
// builds the next table read or the final result into an output register.
// Depends on ptw_pkg, ptw_if.
module ptw_back
   import ptw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ptw_csr_if.sink   csr,
   ptw_rsp_if.source rsp,
   input  logic      head_valid,
   input  qent_type  head,
   output logic      head_pop
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_PDPT = 2'd1;
   localparam logic [1:0] PH_DIR  = 2'd2;
   localparam logic [1:0] PH_TAB  = 2'd3;

   logic        pae_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] vaddr_ff, vaddr_in;

   logic        out_valid_ff, out_valid_in;
   logic        kind_ff, kind_in;
   logic [31:0] raddr_ff, raddr_in;
   logic        wide_ff, wide_in;
   logic [31:0] paddr_ff, paddr_in;
   logic        fault_ff, fault_in;

   logic        emit;
   logic [31:0] root, va_new, base;
   logic [31:0] entry_lo;

   assign csr.ready = 1'b1;

   assign head_pop = head_valid && (!out_valid_ff || rsp.ready);

   assign root     = head.payload[63:32];
   assign va_new   = head.payload[31:0];
   assign entry_lo = head.payload[31:0];
   // Both modes take the base from bits 31:12 once truncated to 32 bits.
   assign base     = {entry_lo[31:12], 12'h000};

   always_comb begin
      phase_in = phase_ff;
      vaddr_in = vaddr_ff;
      emit     = 1'b0;
      kind_in  = KIND_READ;
      raddr_in = '0;
      wide_in  = 1'b0;
      paddr_in = '0;
      fault_in = 1'b0;
      if (head.is_start) begin
         emit     = 1'b1;
         vaddr_in = va_new;
         wide_in  = pae_ff;
         if (pae_ff) begin
            phase_in = PH_PDPT;
            raddr_in = (root & PDPT_ROOT_MASK) + {27'd0, va_new[31:30], 3'b000};
         end else begin
            phase_in = PH_DIR;
            raddr_in = (root & DIR_ROOT_MASK) + {20'd0, va_new[31:22], 2'b00};
         end
      end else if (phase_ff != PH_IDLE) begin
         emit = 1'b1;
         if (!entry_lo[0]) begin
            phase_in = PH_IDLE;
            kind_in  = KIND_DONE;
            fault_in = 1'b1;
         end else begin
            case (phase_ff)
               PH_PDPT, PH_DIR: begin
                  if (phase_ff == PH_PDPT && pae_ff) begin
                     phase_in = PH_DIR;
                     wide_in  = 1'b1;
                     raddr_in = base + {20'd0, vaddr_ff[29:21], 3'b000};
                  end else if (entry_lo[7]) begin
                     // large page
                     phase_in = PH_IDLE;
                     kind_in  = KIND_DONE;
                     paddr_in = pae_ff ? {entry_lo[31:21], vaddr_ff[20:0]}
                                       : {entry_lo[31:22], vaddr_ff[21:0]};
                  end else begin
                     phase_in = PH_TAB;
                     wide_in  = pae_ff;
                     raddr_in = pae_ff ? base + {20'd0, vaddr_ff[20:12], 3'b000}
                                       : base + {20'd0, vaddr_ff[21:12], 2'b00};
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  kind_in  = KIND_DONE;
                  paddr_in = {entry_lo[31:12], vaddr_ff[11:0]};
               end
            endcase
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (head_pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pae_ff       <= 1'b0;
         phase_ff     <= PH_IDLE;
         vaddr_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            pae_ff <= csr.pae_mode;
         end
         if (head_pop) begin
            phase_ff <= phase_in;
            vaddr_ff <= vaddr_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop && emit) begin
         kind_ff  <= kind_in;
         raddr_ff <= raddr_in;
         wide_ff  <= wide_in;
         paddr_ff <= paddr_in;
         fault_ff <= fault_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.read_addr   = raddr_ff;
   assign rsp.read_wide   = wide_ff;
   assign rsp.phys_addr   = paddr_ff;
   assign rsp.fault       = fault_ff;

endmodule

// File: rtl/core/ptw_checker.sv
`timescale 1ns / 1ps
// ptw_checker: port-level assertions for the walker, bound to the top level.
// Depends on ptw_pkg.
module ptw_checker
   import ptw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        result_kind,
   input logic [31:0] read_addr,
   input logic        read_wide,
   input logic [31:0] phys_addr,
   input logic        fault
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_addr) && $stable(phys_addr))
      else $error("rsp payload changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == KIND_DONE |-> read_addr == 32'd0 && !read_wide)
      else $error("finished result carries a read address");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == KIND_READ |-> phys_addr == 32'd0 && !fault)
      else $error("read request carries a translation");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault |-> phys_addr == 32'd0)
      else $error("faulting result with nonzero address");

endmodule

bind x86_page_table_walker ptw_checker u_ptw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .result_kind (rsp.result_kind),
   .read_addr   (rsp.read_addr),
   .read_wide   (rsp.read_wide),
   .phys_addr   (rsp.phys_addr),
   .fault       (rsp.fault)
);

// File: tb/x86_page_table_walker_test.sv
`timescale 1ns / 1ps
// Self-checking bench for x86_page_table_walker: directed and random walks in
// classic and PAE modes, checked against a cycle-free translation predictor.
// Depends on ptw_pkg, ptw_if and the walker RTL.
module x86_page_table_walker_test;
   import ptw_pkg::*;

   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned WALK_ITEMS    = 1400;
   localparam int unsigned RANDOM_PHASES = 6;

   typedef enum logic [1:0] {WALK_IDLE, WALK_PDPT, WALK_DIR, WALK_TAB} walk_step_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] read_addr;
      logic        read_wide;
      logic [31:0] phys_addr;
      logic        fault;
   } walk_result_type;

   class walk_tracker_type;
      bit              pae_mode;
      walk_step_type   step;
      logic [31:0]     held_vaddr;
      walk_result_type awaited[$];
      int unsigned     mismatches;

      function new();
         pae_mode = 1'b0;
         step = WALK_IDLE;
         held_vaddr = '0;
         mismatches = 0;
      endfunction

      function void set_mode(bit mode);
         pae_mode = mode;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Advances the walk for one transferred request item; returns 1 if it
      // yields a response.
      function bit note_request_item(logic cmd, logic [31:0] root, logic [31:0] va,
                                     logic [63:0] rd);
         walk_result_type r;
         logic [63:0]  e;
         logic [31:0]  base;
         logic [31:0]  dir_off;
         logic [31:0]  tab_off;
         r = '0;
         if (cmd == CMD_START) begin
            held_vaddr = va;
            r.result_kind = KIND_READ;
            if (pae_mode) begin
               step = WALK_PDPT;
               r.read_addr = (root & PDPT_ROOT_MASK) + {27'd0, va[31:30], 3'b000};
               r.read_wide = 1'b1;
            end else begin
               step = WALK_DIR;
               r.read_addr = (root & DIR_ROOT_MASK) + {20'd0, va[31:22], 2'b00};
            end
            awaited.push_back(r);
            return 1'b1;
         end
         if (step == WALK_IDLE) return 1'b0;
         e = pae_mode ? rd : {32'd0, rd[31:0]};
         // both modes keep entry bits 31:12 once truncated to 32 bits
         base = {e[31:12], 12'h000};
         dir_off = pae_mode ? {20'd0, held_vaddr[29:21], 3'b000}
                            : {20'd0, held_vaddr[31:22], 2'b00};
         tab_off = pae_mode ? {20'd0, held_vaddr[20:12], 3'b000}
                            : {20'd0, held_vaddr[21:12], 2'b00};
         if (!e[0]) begin
            step = WALK_IDLE;
            r.result_kind = KIND_DONE;
            r.fault = 1'b1;
         end else if (step == WALK_PDPT && pae_mode) begin
            step = WALK_DIR;
            r.result_kind = KIND_READ;
            r.read_addr = base + dir_off;
            r.read_wide = 1'b1;
         end else if (step == WALK_PDPT || step == WALK_DIR) begin
            if (e[7]) begin
               step = WALK_IDLE;
               r.result_kind = KIND_DONE;
               r.phys_addr = pae_mode ? {e[31:21], held_vaddr[20:0]}
                                      : {e[31:22], held_vaddr[21:0]};
            end else begin
               step = WALK_TAB;
               r.result_kind = KIND_READ;
               r.read_addr = base + tab_off;
               r.read_wide = pae_mode;
            end
         end else begin
            step = WALK_IDLE;
            r.result_kind = KIND_DONE;
            r.phys_addr = base | {20'd0, held_vaddr[11:0]};
         end
         awaited.push_back(r);
         return 1'b1;
      endfunction

      task report(string what);
         if (mismatches < 50) $display("%0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_response(walk_result_type got);
         walk_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("response with none awaited: kind %0d addr %h phys %h",
                             got.result_kind, got.read_addr, got.phys_addr));
            return;
         end
         want = awaited.pop_front();
         if (got.result_kind !== want.result_kind)
            report($sformatf("result_kind %0d, want %0d", got.result_kind,
                             want.result_kind));
         if (got.read_addr !== want.read_addr)
            report($sformatf("read_addr %h, want %h", got.read_addr, want.read_addr));
         if (got.read_wide !== want.read_wide)
            report($sformatf("read_wide %0d, want %0d", got.read_wide, want.read_wide));
         if (got.phys_addr !== want.phys_addr)
            report($sformatf("phys_addr %h, want %h", got.phys_addr, want.phys_addr));
         if (got.fault !== want.fault)
            report($sformatf("fault %0d, want %0d", got.fault, want.fault));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ptw_req_if req_ch ();
   ptw_rsp_if rsp_ch ();
   ptw_csr_if csr_ch ();

   x86_page_table_walker DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   walk_tracker_type tracker = new();
   int unsigned walk_items = 0;   // items that produced a response
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned cycle_count = 0;
   int unsigned style_left = 0;
   logic [1:0]  stall_style = 2'd0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side stalls on its own pattern, re-chosen whenever a random countdown expires
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (style_left == 0) begin
         stall_style <= 2'($urandom_range(0, 3));
         style_left <= $urandom_range(20, 80);
      end else begin
         style_left <= style_left - 1;
      end
      case (stall_style)
         2'd0: rsp_ch.ready <= 1'b1;
         2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ch.ready <= (cycle_count[1:0] == 2'd0);
         default: rsp_ch.ready <= cycle_count[3];
      endcase
   end

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         tracker.check_response('{rsp_ch.result_kind, rsp_ch.read_addr, rsp_ch.read_wide,
                                  rsp_ch.phys_addr, rsp_ch.fault});
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("x86_page_table_walker_test failed");
         $finish;
      end
   end

   function automatic logic [31:0] random_addr();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 32'h0000_0000;
      if (pick == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // mostly present entries, some large pages
   function automatic logic [63:0] random_entry();
      logic [63:0] e;
      e = {$urandom, $urandom};
      e[0] = ($urandom_range(0, 11) != 0);
      e[7] = ($urandom_range(0, 2) == 0);
      return e;
   endfunction

   task automatic send_item(input logic cmd, input logic [31:0] root,
                            input logic [31:0] va, input logic [63:0] rd);
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.root_base <= root;
      req_ch.virt_addr <= va;
      req_ch.read_data <= rd;
      do @(posedge clock); while (!req_ch.ready);
      if (tracker.note_request_item(cmd, root, va, rd)) walk_items++;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   // drain everything in flight, then let the pipeline settle
   task automatic quiesce();
      if (req_ch.valid) req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      csr_ch.valid <= 1'b1;
      csr_ch.pae_mode <= mode;
      do @(posedge clock); while (!csr_ch.ready);
      tracker.set_mode(mode);
      csr_ch.valid <= 1'b0;
   endtask

   // mostly full walks with random entries; some cut short, some stray data
   task automatic random_walk();
      int unsigned pick;
      int unsigned steps;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         send_item(CMD_DATA, $urandom, $urandom, random_entry());
      end else begin
         steps = tracker.pae_mode ? 3 : 2;
         if (pick < 14) steps = $urandom_range(0, steps);
         send_item(CMD_START, random_addr(), random_addr(), random_entry());
         repeat (steps) send_item(CMD_DATA, $urandom, $urandom, random_entry());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_START;
      req_ch.root_base = '0;
      req_ch.virt_addr = '0;
      req_ch.read_data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.pae_mode = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // classic mode
      write_mode(1'b0);
      send_item(CMD_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF); // stray data
      send_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FF7F);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(CMD_START, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0);                               // fault
      send_item(CMD_START, 32'h1234_5678, 32'hFFFF_FFFF, 64'h0);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0000_0000_FFFF_FFFF);             // 4 MB page
      send_item(CMD_START, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 64'h0);
      send_item(CMD_START, 32'h0BAD_F00D, 32'hDEAD_BEEF, 64'h0);              // restart
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_0000_1001);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFE);             // fault at table

      // PAE mode
      quiesce();
      write_mode(1'b1);
      send_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFE);             // no PDPT entry
      send_item(CMD_START, 32'h0000_001F, 32'hC000_0000, 64'h0);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);             // 2 MB page
      send_item(CMD_START, 32'h8000_0020, 32'h7FFF_FFFF, 64'h0);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0000_000F_0000_1001);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0000_0001_0000_2001);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0000_000F_FFFF_F001);
      send_item(CMD_START, 32'h4000_0000, 32'h89AB_CDEF, 64'h0);

      // mode drops to classic with a PDPT read outstanding
      quiesce();
      write_mode(1'b0);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0000_0000_0030_0001);
      send_item(CMD_DATA, 32'h0, 32'h0, 64'h0000_0000_0040_0001);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiesce();
         write_mode(p[0] == 1'b0);
         while (walk_items < (p + 1) * WALK_ITEMS / RANDOM_PHASES) random_walk();
      end

      quiesce();
      if (tracker.mismatches == 0)
         $display("x86_page_table_walker_test passed");
      else
         $display("x86_page_table_walker_test failed");
      $finish;
   end

endmodule
